// ----- hdl/wsf_pkg.sv -----
package wsf_pkg;

  localparam int CHAR_W    = 8;
  localparam int MASK_W    = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 1;

  // Byte codes with a fixed meaning in the text stream.
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_STOP  = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MASK_CHARS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LENGTH = 1'd1;

  // Verdict of the suffix comparator, valid for one cycle when done is set.
  typedef struct packed {
    logic done;
    logic hit;
  } match_res_t;

endpackage

// ----- hdl/wsf_match.sv -----
module wsf_match #(
  parameter int MAX_MASK = 8,
  parameter int CNT_W    = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [8*MAX_MASK-1:0]         mask_chars,
  input  logic [wsf_pkg::LEN_W-1:0]     mask_len,
  input  logic [8*MAX_MASK-1:0]         tail_chars,
  input  logic [CNT_W-1:0]              word_cnt,
  input  logic                          overflowed,
  output wsf_pkg::match_res_t           res
);

  localparam int TAIL_W = 8 * MAX_MASK;

  logic                      busy_r;
  logic                      done_r;
  logic                      hit_r;
  logic [TAIL_W-1:0]         m_sh_r;
  logic [TAIL_W-1:0]         t_sh_r;
  logic [wsf_pkg::LEN_W-1:0] left_r;
  logic                      byte_ok;
  logic                      too_short;

  // One byte pair is compared per cycle, both words shifting down a byte.
  assign byte_ok = (m_sh_r[7:0] == wsf_pkg::CH_STAR) || (m_sh_r[7:0] == t_sh_r[7:0]);
  assign too_short = !overflowed &&
                     ({{wsf_pkg::LEN_W{1'b0}}, word_cnt} < {{CNT_W{1'b0}}, mask_len});

  always_ff @(posedge clk) begin
    m_sh_r <= m_sh_r;
    t_sh_r <= t_sh_r;
    left_r <= left_r;
    if (start) begin
      m_sh_r <= mask_chars;
      t_sh_r <= tail_chars;
      left_r <= mask_len;
    end else if (busy_r) begin
      m_sh_r <= m_sh_r >> 8;
      t_sh_r <= t_sh_r >> 8;
      left_r <= left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (mask_len == '0) begin
          done_r <= 1'b1;
          hit_r  <= 1'b1;
        end else if (too_short) begin
          done_r <= 1'b1;
          hit_r  <= 1'b0;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (!byte_ok) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          hit_r  <= 1'b0;
        end else if (left_r == wsf_pkg::LEN_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          hit_r  <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.hit  = hit_r;

endmodule

// ----- hdl/wildcard_suffix_word_filter.sv -----
// Streaming word filter with a wildcard suffix mask.
//
// Input channel (in_valid / in_stall): one transaction carries a text byte or,
// with in_line_end set, an end-of-line mark. Space, comma and full stop end a
// word. Output channel (out_valid / out_stall): one transaction per emitted
// byte; out_last marks the final byte caused by one input transaction.
//
// A word byte is taken and the block is ready again at once.
// A separator or line end with a pending word starts the suffix comparator,
// which checks one mask byte per cycle up to the mask length. A kept word
// then leaves at one byte per cycle while the receiver keeps up, through the
// output register fed by the registered read port, followed by a space
// and, for a line end, a newline. While a word is being judged or sent out,
// in_stall stays high. When the receiver stalls, the output register holds its
// transaction and the sequencer waits; nothing is dropped.
//
// Reset clears the word state, the mask registers and the output's valid
// state. The word store needs no clearing pass: only written entries are read.
// Configuration writes (cfg_valid / cfg_ready) are always taken at once.
module wildcard_suffix_word_filter #(
  parameter int MAX_WORD = 32,
  parameter int MAX_MASK = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wsf_pkg::CHAR_W-1:0]        in_char_code,
  input  logic                              in_line_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wsf_pkg::CHAR_W-1:0]        out_char,
  output logic                              out_last,
  output logic                              out_truncated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsf_pkg::MASK_W-1:0]        cfg_data
);

  localparam int IDX_W  = $clog2(MAX_WORD);
  localparam int CNT_W  = $clog2(MAX_WORD + 1);
  localparam int TAIL_W = 8 * MAX_MASK;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_EMIT,
    S_SPACE,
    S_NL
  } state_t;

  // Configuration registers.
  logic [wsf_pkg::MASK_W-1:0] mask_chars_r;
  logic [wsf_pkg::LEN_W-1:0]  mask_length_r;
  logic [wsf_pkg::LEN_W-1:0]  mask_len_eff;

  // Word state and sequencer.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TAIL_W-1:0] tail_r, tail_nxt;
  logic              ovf_r, ovf_nxt;
  logic              le_pend_r, le_pend_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic [wsf_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_trunc_r, out_trunc_nxt;

  // Word store with a registered read port.
  logic [wsf_pkg::CHAR_W-1:0] word_store [MAX_WORD];
  logic [wsf_pkg::CHAR_W-1:0] rd_data_r;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_en;

  logic                  in_acc;
  logic                  is_sep;
  logic                  slot_free;
  logic                  match_start;
  wsf_pkg::match_res_t   match_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_sep    = in_line_end || (in_char_code == wsf_pkg::CH_SPACE) ||
                     (in_char_code == wsf_pkg::CH_COMMA) ||
                     (in_char_code == wsf_pkg::CH_STOP);
  assign slot_free = !out_valid_r || !out_stall;

  // A mask length above the comparator's reach counts as the full reach.
  assign mask_len_eff = (mask_length_r > wsf_pkg::LEN_W'(MAX_MASK)) ?
                        wsf_pkg::LEN_W'(MAX_MASK) : mask_length_r;

  // The comparator is only started for a pending word; an empty word is
  // skipped straight to the newline or back to idle.
  assign match_start = in_acc && is_sep && (cnt_r != '0);

  assign wr_en = in_acc && !is_sep && (cnt_r < CNT_W'(MAX_WORD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_chars_r  <= '0;
      mask_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsf_pkg::REG_MASK_CHARS:  mask_chars_r  <= cfg_data;
        wsf_pkg::REG_MASK_LENGTH: mask_length_r <= cfg_data[wsf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  wsf_match #(
    .MAX_MASK (MAX_MASK),
    .CNT_W    (CNT_W)
  ) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (match_start),
    .mask_chars (mask_chars_r[TAIL_W-1:0]),
    .mask_len   (mask_len_eff),
    .tail_chars (tail_r),
    .word_cnt   (cnt_r),
    .overflowed (ovf_r),
    .res        (match_res)
  );

  // Read address runs one ahead of the byte being placed in the output
  // register, so the store delivers one byte per cycle while the receiver
  // keeps up.
  always_comb begin
    case (state_r)
      S_MATCH: rd_addr = '0;
      S_EMIT: begin
        if (slot_free && ((idx_r + 1'b1) < cnt_r)) begin
          rd_addr = idx_r[IDX_W-1:0] + 1'b1;
        end else begin
          rd_addr = idx_r[IDX_W-1:0];
        end
      end
      default: rd_addr = idx_r[IDX_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_store[cnt_r[IDX_W-1:0]] <= in_char_code;
    end
    rd_data_r <= word_store[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    tail_nxt      = tail_r;
    ovf_nxt       = ovf_r;
    le_pend_nxt   = le_pend_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_trunc_nxt = out_trunc_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!is_sep) begin
            if (cnt_r < CNT_W'(MAX_WORD)) begin
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
            tail_nxt = (tail_r << 8) | TAIL_W'(in_char_code);
          end else begin
            le_pend_nxt = in_line_end;
            if (cnt_r != '0) begin
              state_nxt = S_MATCH;
            end else if (in_line_end) begin
              state_nxt = S_NL;
            end
          end
        end
      end

      S_MATCH: begin
        if (match_res.done) begin
          if (match_res.hit) begin
            // Dropped word: clear it and go on to the newline if one is due.
            cnt_nxt   = '0;
            tail_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = le_pend_r ? S_NL : S_IDLE;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rd_data_r;
          out_last_nxt  = 1'b0;
          out_trunc_nxt = ovf_r;
          idx_nxt       = idx_r + 1'b1;
          if ((idx_r + 1'b1) == cnt_r) begin
            state_nxt = S_SPACE;
          end
        end
      end

      S_SPACE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = wsf_pkg::CH_SPACE;
          out_last_nxt  = !le_pend_r;
          out_trunc_nxt = 1'b0;
          cnt_nxt       = '0;
          tail_nxt      = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = le_pend_r ? S_NL : S_IDLE;
        end
      end

      S_NL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = wsf_pkg::CH_NL;
          out_last_nxt  = 1'b1;
          out_trunc_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tail_r      <= '0;
      ovf_r       <= 1'b0;
      le_pend_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tail_r      <= tail_nxt;
      ovf_r       <= ovf_nxt;
      le_pend_r   <= le_pend_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

  // The comparator only reports while the sequencer is waiting for it.
  a_match_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    match_res.done |-> (state_r == S_MATCH))
    else $error("suffix comparator finished outside the match state");

  // An overflowed word always holds a full store.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CNT_W'(MAX_WORD)))
    else $error("overflow flag set with a partly filled word store");

  // Whenever the sequencer comes back to idle, the finished word is gone.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && ($past(state_r) != S_IDLE) |-> (cnt_r == '0) && !ovf_r)
    else $error("word state left over after a word was finished");

  // The read index never runs past the held word during the byte phase.
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (idx_r < cnt_r))
    else $error("word read index ran past the held word");

endmodule

// ----- dv/wildcard_suffix_word_filter_tb.sv -----
module wildcard_suffix_word_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_MAX      = 32;
  localparam int MASK_MAX      = 8;
  // Allow a good margin after the last byte for a dropped word's verdict.
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 55;
  localparam logic [wsf_pkg::CHAR_W-1:0] LETTER_A = 8'h61;

  // One input transaction: a text byte, or a line end when line_end is set.
  typedef struct packed {
    logic [wsf_pkg::CHAR_W-1:0] code;
    logic                       line_end;
  } text_item_t;

  // One output transaction as the filter should emit it.
  typedef struct packed {
    logic [wsf_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       truncated;
  } emitted_byte_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [wsf_pkg::CHAR_W-1:0]    in_char_code = '0;
  logic                          in_line_end = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [wsf_pkg::CHAR_W-1:0]    out_char;
  logic                          out_last;
  logic                          out_truncated;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [wsf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wsf_pkg::MASK_W-1:0]    cfg_data = '0;

  wildcard_suffix_word_filter #(
    .MAX_WORD(WORD_MAX),
    .MAX_MASK(MASK_MAX)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_line_end  (in_line_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last     (out_last),
    .out_truncated(out_truncated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Text transactions waiting for the driver, and the bytes the filter still owes us.
  text_item_t    text_queue[$];
  emitted_byte_t expected_bytes[$];
  emitted_byte_t expected_byte;
  text_item_t    next_item;
  int            queued_count = 0;
  int            errors = 0;

  // Shadow copy of the filter: the word held so far and the mask registers.
  logic [wsf_pkg::CHAR_W-1:0] word_bytes[WORD_MAX];
  int                         word_len = 0;
  logic [wsf_pkg::MASK_W-1:0] word_tail = '0;
  logic                       word_cut = 1'b0;
  logic [wsf_pkg::MASK_W-1:0] mask_bytes = '0;
  logic [wsf_pkg::LEN_W-1:0]  mask_len = '0;

  // Handshake bookkeeping for the edge-triggered processes.
  bit in_taken = 1'b0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_phase_left = 0;
  int stall_tick = 0;

  // A finished word is dropped when it is long enough and every mask byte, counted
  // from the end, is a wildcard or equals the word's byte at that place. A zero
  // mask length drops everything, and lengths above the mask width are clamped.
  function automatic bit suffix_matches();
    int n;
    n = mask_len;
    if (n == 0) return 1'b1;
    if (n > MASK_MAX) n = MASK_MAX;
    if (!word_cut && word_len < n) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (mask_bytes[8*i +: 8] != wsf_pkg::CH_STAR &&
          mask_bytes[8*i +: 8] != word_tail[8*i +: 8])
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the shadow filter by one accepted transaction and queues the bytes it
  // should produce. Only the first WORD_MAX bytes of a word are kept for output,
  // but the tail register always follows the true end of the word.
  task automatic predict_filter(input logic [wsf_pkg::CHAR_W-1:0] code, input logic eol);
    emitted_byte_t batch[WORD_MAX + 2];
    int n;
    n = 0;
    if (eol || code == wsf_pkg::CH_SPACE || code == wsf_pkg::CH_COMMA ||
        code == wsf_pkg::CH_STOP) begin
      if (word_len != 0 && !suffix_matches()) begin
        for (int i = 0; i < word_len; i++) begin
          batch[n] = '{word_bytes[i], 1'b0, word_cut};
          n++;
        end
        batch[n] = '{wsf_pkg::CH_SPACE, 1'b0, 1'b0};
        n++;
      end
      word_len  = 0;
      word_tail = '0;
      word_cut  = 1'b0;
      if (eol) begin
        batch[n] = '{wsf_pkg::CH_NL, 1'b0, 1'b0};
        n++;
      end
    end else begin
      if (word_len < WORD_MAX) begin
        word_bytes[word_len] = code;
        word_len++;
      end else begin
        word_cut = 1'b1;
      end
      word_tail = {word_tail[wsf_pkg::MASK_W-wsf_pkg::CHAR_W-1:0], code};
    end
    for (int i = 0; i < n; i++) begin
      batch[i].last = (i == n - 1);
      expected_bytes.insert(expected_bytes.size(), batch[i]);
    end
  endtask

  task automatic send_byte(input logic [wsf_pkg::CHAR_W-1:0] code);
    text_queue.insert(text_queue.size(), text_item_t'{code, 1'b0});
    queued_count++;
  endtask

  // The byte that travels with a line end is meaningless, so callers pass any value.
  task automatic send_eol(input logic [wsf_pkg::CHAR_W-1:0] code);
    text_queue.insert(text_queue.size(), text_item_t'{code, 1'b1});
    queued_count++;
  endtask

  // Word bytes lean towards the mask's own bytes and a tiny alphabet so that
  // matches and near misses are common; the rest is raw noise.
  function automatic logic [wsf_pkg::CHAR_W-1:0] pick_word_byte();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return mask_bytes[8*$urandom_range(0, MASK_MAX - 1) +: 8];
    if (k < 8) return wsf_pkg::CHAR_W'(LETTER_A + $urandom_range(0, 2));
    return wsf_pkg::CHAR_W'($urandom_range(0, 255));
  endfunction

  // Mostly short words, some medium ones, and now and then one close to or past
  // the word store's size, often long enough to overflow it.
  function automatic int pick_word_len();
    int k;
    k = $urandom_range(0, 24);
    if (k == 0) return $urandom_range(WORD_MAX - 1, WORD_MAX + 10);
    if (k < 5) return $urandom_range(6, 12);
    return $urandom_range(1, 6);
  endfunction

  // Half of the words are given the mask's suffix, with wildcards filled at random.
  task automatic send_word(input int len);
    int tail_n;
    tail_n = 0;
    if ($urandom_range(0, 1) == 1) tail_n = (mask_len > MASK_MAX) ? MASK_MAX : mask_len;
    if (tail_n > len) len = tail_n;
    for (int i = len - 1; i >= 0; i--) begin
      if (i < tail_n && mask_bytes[8*i +: 8] != wsf_pkg::CH_STAR)
        send_byte(mask_bytes[8*i +: 8]);
      else send_byte(pick_word_byte());
    end
  endtask

  task automatic send_separator();
    case ($urandom_range(0, 7))
      0, 1, 2: send_byte(wsf_pkg::CH_SPACE);
      3:       send_byte(wsf_pkg::CH_COMMA);
      4:       send_byte(wsf_pkg::CH_STOP);
      5: begin
        // Two separators in a row leave an empty word behind.
        send_byte(wsf_pkg::CH_COMMA);
        send_byte(wsf_pkg::CH_SPACE);
      end
      default: send_eol(wsf_pkg::CHAR_W'($urandom_range(0, 255)));
    endcase
  endtask

  function automatic logic [wsf_pkg::MASK_W-1:0] alphabet_mask();
    logic [wsf_pkg::MASK_W-1:0] m;
    for (int i = 0; i < MASK_MAX; i++) begin
      if ($urandom_range(0, 2) == 0) m[8*i +: 8] = wsf_pkg::CH_STAR;
      else m[8*i +: 8] = wsf_pkg::CHAR_W'(LETTER_A + $urandom_range(0, 2));
    end
    return m;
  endfunction

  // Register writes are only issued while the filter is idle, so the shadow
  // registers are updated as soon as the write transaction completes.
  task automatic write_reg(input logic [wsf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wsf_pkg::MASK_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == wsf_pkg::REG_MASK_CHARS) mask_bytes = data;
    else mask_len = data[wsf_pkg::LEN_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued transaction has been taken and every expected byte
  // has come back, then lets a dropped word's verdict run out before returning.
  task automatic drain();
    int waited;
    waited = 0;
    while ((text_queue.size() != 0 || in_valid || expected_bytes.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_LIMIT) begin
      errors++;
      $display("%0t: filter stuck, %0d text and %0d output transactions outstanding",
               $time, text_queue.size(), expected_bytes.size());
      expected_bytes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender. New data is presented on the falling edge once the previous
  // transaction has gone through. It works in bursts of random length separated
  // by random gaps; a gap of zero gives back-to-back stretches.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (text_queue.size() != 0) begin
        next_item = text_queue.pop_front();
        in_valid     <= 1'b1;
        in_char_code <= next_item.code;
        in_line_end  <= next_item.line_end;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;
            2, 3:    gap_left = $urandom_range(1, 3);
            4:       gap_left = $urandom_range(4, 12);
            default: gap_left = 0;
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. It cycles through stall patterns of its own: never, coin toss,
  // one cycle in three, and heavy. A long hold-off, when requested, keeps it
  // stalled so that the filter backs up into its input channel while the sender
  // keeps offering transactions.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (stall_phase_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(16, 96);
    end else begin
      stall_phase_left--;
    end
    stall_tick++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        2:       out_stall <= (stall_tick % 3 == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor. On each rising edge an accepted input transaction advances the
  // shadow filter, and an accepted output transaction is checked against the
  // oldest byte still owed.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_filter(in_char_code, in_line_end);
        in_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected output, expected nothing, got char %h last %b trunc %b",
                   $time, out_char, out_last, out_truncated);
        end else begin
          expected_byte = expected_bytes.pop_front();
          if (out_char !== expected_byte.ch || out_last !== expected_byte.last ||
              out_truncated !== expected_byte.truncated) begin
            errors++;
            $display("%0t: mismatch, expected char %h last %b trunc %b,",
                     $time, expected_byte.ch, expected_byte.last,
                     expected_byte.truncated);
            $display("%0t:   got char %h last %b trunc %b",
                     $time, out_char, out_last, out_truncated);
          end
        end
      end
    end
  end

  // Safety net in case the filter locks up altogether.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [wsf_pkg::MASK_W-1:0] chars;
    logic [wsf_pkg::MASK_W-1:0] len_word;
    logic [wsf_pkg::LEN_W-1:0]  len;
    int                         base;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // With the reset mask length of zero every word is dropped and only the
    // newline comes out. A zero byte is an ordinary word character.
    send_byte("x");
    send_byte(8'h00);
    send_byte(wsf_pkg::CH_SPACE);
    send_eol(8'hFF);
    drain();

    // Mask "*b": words whose last byte is 'b' and that have two bytes or more.
    write_reg(wsf_pkg::REG_MASK_CHARS, {48'h0, wsf_pkg::CH_STAR, 8'h62});
    write_reg(wsf_pkg::REG_MASK_LENGTH, {60'h0, 4'd2});
    send_byte("a");
    send_byte("b");
    send_byte(wsf_pkg::CH_COMMA);       // dropped
    send_byte("b");
    send_byte("a");
    send_byte(wsf_pkg::CH_STOP);        // kept
    send_byte("b");
    send_byte(wsf_pkg::CH_SPACE);       // kept: shorter than the mask
    send_byte(wsf_pkg::CH_COMMA);       // empty word
    send_byte(8'hFF);
    send_byte(wsf_pkg::CH_NL);          // a newline byte inside a word is just a character
    send_eol(wsf_pkg::CH_SPACE);        // kept, then the newline
    send_eol(8'h00);                    // line end with nothing pending
    drain();

    // A length above the mask width behaves as eight wildcards: short words survive.
    write_reg(wsf_pkg::REG_MASK_CHARS, {MASK_MAX{wsf_pkg::CH_STAR}});
    write_reg(wsf_pkg::REG_MASK_LENGTH, {60'h0, 4'hF});
    send_byte("a");
    send_byte("b");
    send_byte("c");
    send_eol(wsf_pkg::CH_COMMA);
    drain();

    // Random phases, each under its own mask, the register extremes among them.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          chars = '0;
          len = wsf_pkg::LEN_W'(MASK_MAX);
        end
        1: begin
          chars = '1;
          len = wsf_pkg::LEN_W'(1);
        end
        2: begin
          chars = alphabet_mask();
          len = wsf_pkg::LEN_W'($urandom_range(1, 3));
        end
        3: begin
          chars = alphabet_mask();
          len = '0;
        end
        4: begin
          chars = alphabet_mask();
          len = 4'hF;
        end
        5: begin
          chars = alphabet_mask();
          len = wsf_pkg::LEN_W'(MASK_MAX);
        end
        6: begin
          chars = {$urandom, $urandom};
          len = wsf_pkg::LEN_W'($urandom_range(1, MASK_MAX));
        end
        default: begin
          chars = alphabet_mask();
          len = wsf_pkg::LEN_W'($urandom_range(0, MASK_MAX));
        end
      endcase
      // Only the low bits of the length register count; the rest is filled at random.
      len_word = {$urandom, $urandom};
      len_word[wsf_pkg::LEN_W-1:0] = len;
      write_reg(wsf_pkg::REG_MASK_CHARS, chars);
      write_reg(wsf_pkg::REG_MASK_LENGTH, len_word);

      if (p == 2) hold_request = 1'b1;

      base = queued_count;
      while (queued_count - base < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) send_byte(wsf_pkg::CHAR_W'($urandom_range(0, 255)));
        end else begin
          send_word(pick_word_len());
          send_separator();
        end
      end
      send_eol(wsf_pkg::CHAR_W'($urandom_range(0, 255)));
      drain();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
